FILE: hdl/tlc_pkg.sv
// Shared types and constants of the two-level cache tag controller.
package tlc_pkg;

    typedef struct packed {
        logic        func;
        logic [31:0] address;
    } req_t;

    typedef struct packed {
        logic       l1_hit;
        logic [2:0] l1_way;
        logic       l1_writeback;
        logic       l2_write_done;
        logic       l2_write_hit;
        logic       l2_write_evict;
        logic       l2_read_done;
        logic       l2_read_hit;
        logic       l2_read_evict;
    } rsp_t;

    typedef struct packed {
        logic [3:0] offset_bits;
        logic [3:0] index_bits;
        logic [3:0] ways;
        logic       fifo;
    } lvl_cfg_t;

    typedef struct packed {
        logic start;
        logic is_write;
    } lvl_cmd_t;

    typedef struct packed {
        logic ready;
        logic done;
        logic hit;
        logic evict;
    } lvl_sts_t;

    localparam logic [2:0] REG_OFFSET_BITS      = 3'd0;
    localparam logic [2:0] REG_L1_INDEX_BITS    = 3'd1;
    localparam logic [2:0] REG_L1_WAYS          = 3'd2;
    localparam logic [2:0] REG_L2_ENABLE        = 3'd3;
    localparam logic [2:0] REG_L2_INDEX_BITS    = 3'd4;
    localparam logic [2:0] REG_L2_WAYS          = 3'd5;
    localparam logic [2:0] REG_REPLACEMENT_MODE = 3'd6;

    localparam logic [3:0] RST_OFFSET_BITS   = 4'd5;
    localparam logic [3:0] RST_L1_INDEX_BITS = 4'd6;
    localparam logic [3:0] RST_L1_WAYS       = 4'd2;
    localparam logic       RST_L2_ENABLE     = 1'b1;
    localparam logic [3:0] RST_L2_INDEX_BITS = 4'd8;
    localparam logic [3:0] RST_L2_WAYS       = 4'd4;
    localparam logic       RST_REPL_MODE     = 1'b0;

endpackage

FILE: hdl/tlc_level.sv
// Tag datapath of one cache level: set memory, hit and victim selection, row update.
module tlc_level #(
    parameter int SETS       = 256,
    parameter int MAX_WAYS   = 8,
    parameter int ADDR_BITS  = 32,
    parameter int STAMP_BITS = 32
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  tlc_pkg::lvl_cfg_t                  cfg,
    input  tlc_pkg::lvl_cmd_t                  cmd,
    input  logic [ADDR_BITS-1:0]               addr,
    output tlc_pkg::lvl_sts_t                  sts,
    output logic [(MAX_WAYS > 1 ? $clog2(MAX_WAYS) : 1)-1:0] way,
    output logic [ADDR_BITS-1:0]               vaddr
);

    localparam int AW     = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int IB_MAX = $clog2(SETS + 1) - 1;
    localparam int WW     = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int CW     = $clog2(MAX_WAYS + 1);

    typedef struct packed {
        logic                  valid;
        logic                  dirty;
        logic [ADDR_BITS-1:0]  tag;
        logic [STAMP_BITS-1:0] stamp;
    } entry_t;

    typedef entry_t [MAX_WAYS-1:0] row_t;

    row_t mem [SETS];

    row_t                  rdata_reg;
    row_t                  row_new;
    logic [AW-1:0]         set_reg;
    logic [ADDR_BITS-1:0]  tag_reg;
    logic                  wr_reg;
    logic [STAMP_BITS-1:0] clock_reg;
    logic                  ph_reg;
    logic                  done_reg;
    logic                  clr_reg;
    logic [AW-1:0]         clr_idx_reg;
    logic                  hit_reg;
    logic                  evict_reg;
    logic [WW-1:0]         way_reg;
    logic [ADDR_BITS-1:0]  vaddr_reg;

    logic [4:0]            ib;
    logic [5:0]            tsh;
    logic [ADDR_BITS-1:0]  imask;
    logic [AW-1:0]         set_c;
    logic [ADDR_BITS-1:0]  tag_c;
    logic [CW-1:0]         nw;
    logic                  hit_f;
    logic                  inv_f;
    logic [WW-1:0]         hit_w;
    logic [WW-1:0]         inv_w;
    logic [WW-1:0]         best;
    logic [WW-1:0]         vict;
    logic                  evict_c;
    logic [ADDR_BITS-1:0]  vaddr_c;

    // Index width saturates at what the set memory can hold.
    assign ib    = ({1'b0, cfg.index_bits} > 5'(IB_MAX)) ? 5'(IB_MAX) : {1'b0, cfg.index_bits};
    assign tsh   = 6'(cfg.offset_bits) + 6'(ib);
    assign imask = (ADDR_BITS'(1) << ib) - ADDR_BITS'(1);
    assign set_c = AW'((addr >> cfg.offset_bits) & imask);
    assign tag_c = addr >> tsh;

    always_comb
    begin
        if (cfg.ways == 4'd0)
            nw = CW'(1);
        else if (32'(cfg.ways) > MAX_WAYS)
            nw = CW'(MAX_WAYS);
        else
            nw = CW'(cfg.ways);
    end

    always_comb
    begin
        row_new = rdata_reg;
        hit_f   = 1'b0;
        inv_f   = 1'b0;
        hit_w   = '0;
        inv_w   = '0;
        best    = '0;
        for (int w = 0; w < MAX_WAYS; w++)
        begin
            if (CW'(w) < nw)
            begin
                if (!hit_f && rdata_reg[w].valid && rdata_reg[w].tag == tag_reg)
                begin
                    hit_f = 1'b1;
                    hit_w = WW'(w);
                end
                if (!inv_f && !rdata_reg[w].valid)
                begin
                    inv_f = 1'b1;
                    inv_w = WW'(w);
                end
                if (w > 0 && rdata_reg[w].stamp < rdata_reg[best].stamp)
                    best = WW'(w);
            end
        end
        vict = inv_f ? inv_w : best;
        if (hit_f)
        begin
            if (!cfg.fifo)
                row_new[hit_w].stamp = clock_reg;
            if (wr_reg)
                row_new[hit_w].dirty = 1'b1;
        end
        else
        begin
            row_new[vict].valid = 1'b1;
            row_new[vict].dirty = wr_reg;
            row_new[vict].tag   = tag_reg;
            row_new[vict].stamp = clock_reg;
        end
        evict_c = !hit_f && rdata_reg[vict].valid && rdata_reg[vict].dirty;
        vaddr_c = ((rdata_reg[vict].tag << ib) | ADDR_BITS'(set_reg)) << cfg.offset_bits;
    end

    always_ff @(posedge clk)
    begin
        if (clr_reg)
            mem[clr_idx_reg] <= '0;
        else if (ph_reg)
            mem[set_reg] <= row_new;
        if (cmd.start)
            rdata_reg <= mem[set_c];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            set_reg <= set_c;
            tag_reg <= tag_c;
            wr_reg  <= cmd.is_write;
        end
        if (ph_reg)
        begin
            hit_reg   <= hit_f;
            evict_reg <= evict_c;
            way_reg   <= hit_f ? hit_w : vict;
            vaddr_reg <= vaddr_c;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clock_reg   <= '0;
            ph_reg      <= 1'b0;
            done_reg    <= 1'b0;
            clr_reg     <= 1'b1;
            clr_idx_reg <= '0;
        end
        else
        begin
            done_reg <= ph_reg;
            ph_reg   <= cmd.start;
            if (cmd.start)
                clock_reg <= clock_reg + STAMP_BITS'(1);
            if (clr_reg)
            begin
                if (clr_idx_reg == AW'(SETS - 1))
                    clr_reg <= 1'b0;
                clr_idx_reg <= clr_idx_reg + AW'(1);
            end
        end
    end

    assign sts.ready = !clr_reg;
    assign sts.done  = done_reg;
    assign sts.hit   = hit_reg;
    assign sts.evict = evict_reg;
    assign way       = way_reg;
    assign vaddr     = vaddr_reg;

endmodule

FILE: hdl/tlc_ctrl.sv
// Sequencer: configuration registers, access state machine and result register.
module tlc_ctrl #(
    parameter int MAX_WAYS  = 8,
    parameter int ADDR_BITS = 32
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     req_valid,
    output logic                     req_stall,
    input  tlc_pkg::req_t            req,
    output logic                     rsp_valid,
    input  logic                     rsp_stall,
    output tlc_pkg::rsp_t            rsp,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [2:0]               cfg_index,
    input  logic [3:0]               cfg_data,
    output tlc_pkg::lvl_cfg_t        l1_cfg,
    output tlc_pkg::lvl_cfg_t        l2_cfg,
    output tlc_pkg::lvl_cmd_t        l1_cmd,
    output tlc_pkg::lvl_cmd_t        l2_cmd,
    input  tlc_pkg::lvl_sts_t        l1_sts,
    input  tlc_pkg::lvl_sts_t        l2_sts,
    input  logic [(MAX_WAYS > 1 ? $clog2(MAX_WAYS) : 1)-1:0] l1_way,
    input  logic [ADDR_BITS-1:0]     l1_vaddr,
    output logic [ADDR_BITS-1:0]     l1_addr,
    output logic [ADDR_BITS-1:0]     l2_addr
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_L1   = 3'd1;
    localparam logic [2:0] S_L2W  = 3'd2;
    localparam logic [2:0] S_L2R  = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;

    logic [2:0]           state_reg, state_next;
    logic [3:0]           offset_reg, l1_ib_reg, l1_ways_reg, l2_ib_reg, l2_ways_reg;
    logic                 l2_en_reg, mode_reg;
    logic [ADDR_BITS-1:0] addr_reg;
    tlc_pkg::rsp_t        flags_reg;
    tlc_pkg::rsp_t        rsp_reg;
    logic                 rsp_valid_reg;
    logic                 accept;
    logic [63:0]          req_addr64;
    logic [31:0]          way32;
    logic                 rsp_free;

    assign cfg_ready  = 1'b1;
    assign req_stall  = (state_reg != S_IDLE) || !l1_sts.ready || !l2_sts.ready;
    assign accept     = req_valid && !req_stall;
    assign req_addr64 = 64'(req.address);
    assign l1_addr    = req_addr64[ADDR_BITS-1:0];
    assign way32      = 32'(l1_way);
    assign rsp_free   = !rsp_valid_reg || !rsp_stall;

    assign l1_cfg = '{offset_bits: offset_reg, index_bits: l1_ib_reg,
                      ways: l1_ways_reg, fifo: mode_reg};
    assign l2_cfg = '{offset_bits: offset_reg, index_bits: l2_ib_reg,
                      ways: l2_ways_reg, fifo: mode_reg};

    // At the end of the first-level lookup the second level starts with the victim
    // write when there is one, otherwise directly with the read of the missing block.
    assign l2_addr = (state_reg == S_L1 && l1_sts.evict) ? l1_vaddr : addr_reg;

    always_comb
    begin
        state_next      = state_reg;
        l1_cmd.start    = accept;
        l1_cmd.is_write = req.func;
        l2_cmd.start    = 1'b0;
        l2_cmd.is_write = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                    state_next = S_L1;
            end
            S_L1:
            begin
                if (l1_sts.done)
                begin
                    if (l1_sts.hit || !l2_en_reg)
                        state_next = S_FIN;
                    else if (l1_sts.evict)
                    begin
                        l2_cmd.start    = 1'b1;
                        l2_cmd.is_write = 1'b1;
                        state_next      = S_L2W;
                    end
                    else
                    begin
                        l2_cmd.start = 1'b1;
                        state_next   = S_L2R;
                    end
                end
            end
            S_L2W:
            begin
                if (l2_sts.done)
                begin
                    l2_cmd.start = 1'b1;
                    state_next   = S_L2R;
                end
            end
            S_L2R:
            begin
                if (l2_sts.done)
                    state_next = S_FIN;
            end
            S_FIN:
            begin
                if (rsp_free)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            addr_reg  <= l1_addr;
            flags_reg <= '0;
        end
        if (state_reg == S_L1 && l1_sts.done)
        begin
            flags_reg.l1_hit       <= l1_sts.hit;
            flags_reg.l1_way       <= way32[2:0];
            flags_reg.l1_writeback <= l1_sts.evict;
        end
        if (state_reg == S_L2W && l2_sts.done)
        begin
            flags_reg.l2_write_done  <= 1'b1;
            flags_reg.l2_write_hit   <= l2_sts.hit;
            flags_reg.l2_write_evict <= l2_sts.evict;
        end
        if (state_reg == S_L2R && l2_sts.done)
        begin
            flags_reg.l2_read_done  <= 1'b1;
            flags_reg.l2_read_hit   <= l2_sts.hit;
            flags_reg.l2_read_evict <= l2_sts.evict;
        end
        if (state_reg == S_FIN && rsp_free)
            rsp_reg <= flags_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
            offset_reg    <= tlc_pkg::RST_OFFSET_BITS;
            l1_ib_reg     <= tlc_pkg::RST_L1_INDEX_BITS;
            l1_ways_reg   <= tlc_pkg::RST_L1_WAYS;
            l2_en_reg     <= tlc_pkg::RST_L2_ENABLE;
            l2_ib_reg     <= tlc_pkg::RST_L2_INDEX_BITS;
            l2_ways_reg   <= tlc_pkg::RST_L2_WAYS;
            mode_reg      <= tlc_pkg::RST_REPL_MODE;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_FIN && rsp_free)
                rsp_valid_reg <= 1'b1;
            else if (rsp_valid_reg && !rsp_stall)
                rsp_valid_reg <= 1'b0;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    tlc_pkg::REG_OFFSET_BITS:      offset_reg  <= cfg_data;
                    tlc_pkg::REG_L1_INDEX_BITS:    l1_ib_reg   <= cfg_data;
                    tlc_pkg::REG_L1_WAYS:          l1_ways_reg <= cfg_data;
                    tlc_pkg::REG_L2_ENABLE:        l2_en_reg   <= cfg_data[0];
                    tlc_pkg::REG_L2_INDEX_BITS:    l2_ib_reg   <= cfg_data;
                    tlc_pkg::REG_L2_WAYS:          l2_ways_reg <= cfg_data;
                    tlc_pkg::REG_REPLACEMENT_MODE: mode_reg    <= cfg_data[0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

FILE: hdl/two_level_cache_tag_controller.sv
// Top level of the two-level write-back cache tag controller.
// Each access transaction is looked up in L1 and, on a miss with L2 enabled, may write
// the dirty L1 victim into L2 and then reads L2; each lookup is a read-modify-write of
// one set row: the row is read into a register, then the hit, the victim and the
// updated row are computed and written back, and the result is registered. A result
// still held by a stalled receiver delays the following item until it is taken.
// After reset a clearing pass zeroes the tag rows; no access is taken meanwhile,
// while configuration writes are always taken. Results leave through an output register,
// so the next access may start while a result waits.
module two_level_cache_tag_controller #(
    parameter int L1_MAX_SETS = 256,
    parameter int L2_MAX_SETS = 2048,
    parameter int MAX_WAYS    = 8,
    parameter int ADDR_BITS   = 32,
    parameter int STAMP_BITS  = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  tlc_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output tlc_pkg::rsp_t rsp,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [2:0]    cfg_index,
    input  logic [3:0]    cfg_data
);

    localparam int WW = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;

    tlc_pkg::lvl_cfg_t    l1_cfg, l2_cfg;
    tlc_pkg::lvl_cmd_t    l1_cmd, l2_cmd;
    tlc_pkg::lvl_sts_t    l1_sts, l2_sts;
    logic [WW-1:0]        l1_way;
    logic [ADDR_BITS-1:0] l1_vaddr, l1_addr, l2_addr;

    tlc_ctrl #(
        .MAX_WAYS (MAX_WAYS),
        .ADDR_BITS(ADDR_BITS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .req      (req),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp      (rsp),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .l1_cfg   (l1_cfg),
        .l2_cfg   (l2_cfg),
        .l1_cmd   (l1_cmd),
        .l2_cmd   (l2_cmd),
        .l1_sts   (l1_sts),
        .l2_sts   (l2_sts),
        .l1_way   (l1_way),
        .l1_vaddr (l1_vaddr),
        .l1_addr  (l1_addr),
        .l2_addr  (l2_addr)
    );

    tlc_level #(
        .SETS      (L1_MAX_SETS),
        .MAX_WAYS  (MAX_WAYS),
        .ADDR_BITS (ADDR_BITS),
        .STAMP_BITS(STAMP_BITS)
    ) u_l1 (
        .clk  (clk),
        .rst_n(rst_n),
        .cfg  (l1_cfg),
        .cmd  (l1_cmd),
        .addr (l1_addr),
        .sts  (l1_sts),
        .way  (l1_way),
        .vaddr(l1_vaddr)
    );

    tlc_level #(
        .SETS      (L2_MAX_SETS),
        .MAX_WAYS  (MAX_WAYS),
        .ADDR_BITS (ADDR_BITS),
        .STAMP_BITS(STAMP_BITS)
    ) u_l2 (
        .clk  (clk),
        .rst_n(rst_n),
        .cfg  (l2_cfg),
        .cmd  (l2_cmd),
        .addr (l2_addr),
        .sts  (l2_sts),
        .way  (),
        .vaddr()
    );

endmodule
